>>> rtl/u8vc_pkg.sv
`default_nettype none

package u8vc_pkg;

    localparam int COUNT_BITS = 31;
    localparam int OUT_BITS   = 31;
    localparam int CP_BITS    = 21;

    localparam logic [7:0]         LEAD_2_MIN   = 8'hC0;
    localparam logic [7:0]         LEAD_3_MIN   = 8'hE0;
    localparam logic [7:0]         LEAD_4_MIN   = 8'hF0;
    localparam logic [7:0]         CONT_MIN     = 8'h80;
    localparam logic [7:0]         CONT_MASK    = 8'hC0;
    localparam logic [CP_BITS-1:0] MIN_2_BYTE   = 21'h00080;
    localparam logic [CP_BITS-1:0] MIN_3_BYTE   = 21'h00800;
    localparam logic [CP_BITS-1:0] MIN_4_BYTE   = 21'h10000;
    localparam logic [CP_BITS-1:0] MAX_CODE     = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURR_MASK    = 21'h1FF800;
    localparam logic [CP_BITS-1:0] SURR_BASE    = 21'h00D800;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OUT_BITS-1:0]   out_count_t;

    typedef enum logic [2:0]
    {
        SEQ_NONE = 3'd0,
        SEQ_TWO  = 3'd2,
        SEQ_THREE = 3'd3,
        SEQ_FOUR = 3'd4
    } seq_len_t;

    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
    endfunction

    function automatic out_count_t clip_out(input count_t v);
        logic [32:0] ext;
        ext = 33'(v);
        clip_out = (ext > 33'h07FFFFFFF) ? {OUT_BITS{1'b1}} : ext[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_validate_and_count.sv
// A result is registered in the result register once the string's last item leaves the input register.
// One byte item per cycle, unless a final item waits on a stalled result; decode and update are combinational.
// The input register refills in the cycle it drains, so items flow without gaps.
// Reset is asynchronous and active low; it clears all string state and stop_at_nul.
// The result register holds a finished item while a new byte is being taken.
`default_nettype none

module utf8_validate_and_count
    import u8vc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                stop_at_nul,
    input  wire logic                data_valid,
    output logic                     data_stall,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     is_valid,
    output logic [OUT_BITS-1:0]      char_count,
    output logic [OUT_BITS-1:0]      error_offset
);

    logic                nul_mode_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;

    count_t              pos_reg,       pos_next;
    count_t              chars_reg,     chars_next;
    logic [1:0]          cont_reg,      cont_next;
    seq_len_t            len_reg,       len_next;
    logic [CP_BITS-1:0]  cp_reg,        cp_next;
    logic                high_reg,      high_next;
    count_t              start_reg,     start_next;
    logic                err_reg,       err_next;
    count_t              err_pos_reg,   err_pos_next;
    logic                ended_reg,     ended_next;

    logic                out_valid_reg;
    logic                out_ok_reg;
    out_count_t          out_count_reg;
    out_count_t          out_offset_reg;

    logic                out_free;
    logic                fire;
    logic                load;
    logic                bad;
    logic [CP_BITS-1:0]  cp_acc;

    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || !result_stall;
    assign fire         = in_valid_reg && (!in_last_reg || out_free);
    assign data_stall   = in_valid_reg && !fire;
    assign load         = data_valid && !data_stall;

    assign result_valid = out_valid_reg;
    assign is_valid     = out_ok_reg;
    assign char_count   = out_count_reg;
    assign error_offset = out_offset_reg;

    always_comb
    begin
        cont_next    = cont_reg;
        len_next     = len_reg;
        cp_next      = cp_reg;
        high_next    = high_reg;
        start_next   = start_reg;
        err_next     = err_reg;
        err_pos_next = err_pos_reg;
        ended_next   = ended_reg;
        chars_next   = chars_reg;
        bad          = 1'b0;
        cp_acc       = CP_BITS'({cp_reg, in_byte_reg[5:0]});

        if (!err_reg && !ended_reg)
        begin
            if (cont_reg == 2'd0)
            begin
                start_next = pos_reg;
                if (in_byte_reg < CONT_MIN)
                begin
                    if (in_byte_reg == 8'h00 && nul_mode_reg)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        chars_next = sat_inc(chars_reg);
                    end
                end
                else if (in_byte_reg < LEAD_2_MIN)
                begin
                    err_next     = 1'b1;
                    err_pos_next = pos_reg;
                    cont_next    = 2'd0;
                end
                else if (in_byte_reg < LEAD_3_MIN)
                begin
                    len_next  = SEQ_TWO;
                    cont_next = 2'd1;
                    cp_next   = CP_BITS'(in_byte_reg[4:0]);
                    high_next = 1'b0;
                end
                else if (in_byte_reg < LEAD_4_MIN)
                begin
                    len_next  = SEQ_THREE;
                    cont_next = 2'd2;
                    cp_next   = CP_BITS'(in_byte_reg[3:0]);
                    high_next = 1'b0;
                end
                else
                begin
                    len_next  = SEQ_FOUR;
                    cont_next = 2'd3;
                    cp_next   = CP_BITS'(in_byte_reg[2:0]);
                    high_next = in_byte_reg[3];
                end
            end
            else if ((in_byte_reg & CONT_MASK) != CONT_MIN)
            begin
                err_next     = 1'b1;
                err_pos_next = start_reg;
                cont_next    = 2'd0;
            end
            else
            begin
                cp_next   = cp_acc;
                cont_next = cont_reg - 2'd1;
                if (cont_reg == 2'd1)
                begin
                    case (len_reg)
                        SEQ_TWO:   bad = cp_acc < MIN_2_BYTE;
                        SEQ_THREE: bad = (cp_acc < MIN_3_BYTE)
                                         || ((cp_acc & SURR_MASK) == SURR_BASE);
                        default:   bad = high_reg || (cp_acc < MIN_4_BYTE)
                                         || (cp_acc > MAX_CODE);
                    endcase
                    if (bad)
                    begin
                        err_next     = 1'b1;
                        err_pos_next = start_reg;
                    end
                    else
                    begin
                        chars_next = sat_inc(chars_reg);
                    end
                end
            end
        end

        pos_next = sat_inc(pos_reg);

        if (in_last_reg && !err_next && !ended_next && cont_next != 2'd0)
        begin
            err_next     = 1'b1;
            err_pos_next = start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nul_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            nul_mode_reg <= stop_at_nul;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            chars_reg   <= '0;
            cont_reg    <= 2'd0;
            len_reg     <= SEQ_NONE;
            cp_reg      <= '0;
            high_reg    <= 1'b0;
            start_reg   <= '0;
            err_reg     <= 1'b0;
            err_pos_reg <= '0;
            ended_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (in_last_reg)
            begin
                pos_reg     <= '0;
                chars_reg   <= '0;
                cont_reg    <= 2'd0;
                len_reg     <= SEQ_NONE;
                cp_reg      <= '0;
                high_reg    <= 1'b0;
                start_reg   <= '0;
                err_reg     <= 1'b0;
                err_pos_reg <= '0;
                ended_reg   <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                chars_reg   <= chars_next;
                cont_reg    <= cont_next;
                len_reg     <= len_next;
                cp_reg      <= cp_next;
                high_reg    <= high_next;
                start_reg   <= start_next;
                err_reg     <= err_next;
                err_pos_reg <= err_pos_next;
                ended_reg   <= ended_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_ok_reg     <= !err_next;
            out_count_reg  <= err_next ? '0 : clip_out(chars_next);
            out_offset_reg <= err_next ? clip_out(err_pos_next) : '0;
        end
    end

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(fire && in_last_reg))
        else $error("Result appeared without a final item.");

    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_valid) |-> (error_offset == '0))
        else $error("Valid result carries an error offset.");

    a_invalid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_valid) |-> (char_count == '0))
        else $error("Invalid result carries a character count.");

    a_no_cont_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (cont_reg == 2'd0))
        else $error("Continuations pending after an error.");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(char_count)
                                            && $stable(error_offset)))
        else $error("Stalled result changed.");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import u8vc_pkg::*;

    typedef struct packed
    {
        logic [7:0] value;
        logic       last;
    } byte_item_t;

    typedef struct packed
    {
        logic       ok;
        out_count_t chars;
        out_count_t err_offset;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             stop_at_nul = 1'b0;
    logic             data_valid = 1'b0;
    logic             data_stall;
    logic [7:0]       data_byte = 8'h00;
    logic             last_byte = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic             is_valid;
    logic [OUT_BITS-1:0] char_count;
    logic [OUT_BITS-1:0] error_offset;

    byte_item_t  byte_queue[$];
    logic [7:0]  str_buf[$];
    verdict_t    expected_verdicts[$];
    byte_item_t  next_item;
    int          bytes_unaccepted = 0;
    int          bytes_queued = 0;
    int          fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    logic        nul_mode = 1'b0;
    count_t      str_pos = '0;
    count_t      str_chars = '0;
    logic [1:0]  cont_needed = '0;
    seq_len_t    seq_kind = SEQ_NONE;
    logic [20:0] cp_acc = '0;
    logic        lead_high = 1'b0;
    count_t      seq_lead_pos = '0;
    logic        has_error = 1'b0;
    count_t      error_pos = '0;
    logic        nul_seen = 1'b0;

    utf8_validate_and_count u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .stop_at_nul  (stop_at_nul),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .is_valid     (is_valid),
        .char_count   (char_count),
        .error_offset (error_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic count_t bump(input count_t v);
        return (&v) ? v : v + count_t'(1);
    endfunction

    task automatic mark_error(input count_t where);
        has_error = 1'b1;
        error_pos = where;
        cont_needed = 2'd0;
    endtask

    task automatic clear_string_state();
        str_pos = '0;
        str_chars = '0;
        cont_needed = 2'd0;
        seq_kind = SEQ_NONE;
        cp_acc = '0;
        lead_high = 1'b0;
        seq_lead_pos = '0;
        has_error = 1'b0;
        error_pos = '0;
        nul_seen = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic bad;
        bad = 1'b0;
        if (cont_needed == 2'd0)
        begin
            seq_lead_pos = str_pos;
            if (b < 8'h80)
            begin
                if (b == 8'h00 && nul_mode)
                    nul_seen = 1'b1;
                else
                    str_chars = bump(str_chars);
            end
            else if (b < 8'hC0)
                mark_error(str_pos);
            else if (b < 8'hE0)
            begin
                seq_kind = SEQ_TWO;
                cont_needed = 2'd1;
                cp_acc = {16'd0, b[4:0]};
                lead_high = 1'b0;
            end
            else if (b < 8'hF0)
            begin
                seq_kind = SEQ_THREE;
                cont_needed = 2'd2;
                cp_acc = {17'd0, b[3:0]};
                lead_high = 1'b0;
            end
            else
            begin
                seq_kind = SEQ_FOUR;
                cont_needed = 2'd3;
                cp_acc = {18'd0, b[2:0]};
                lead_high = b[3];
            end
        end
        else if (b[7:6] != 2'b10)
            mark_error(seq_lead_pos);
        else
        begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_needed = cont_needed - 2'd1;
            if (cont_needed == 2'd0)
            begin
                case (seq_kind)
                    SEQ_TWO:   bad = cp_acc < 21'h80;
                    SEQ_THREE: bad = (cp_acc < 21'h800) || (cp_acc[20:11] == 10'h01B);
                    default:   bad = lead_high || (cp_acc < 21'h10000) || (cp_acc > 21'h10FFFF);
                endcase
                if (bad)
                    mark_error(seq_lead_pos);
                else
                    str_chars = bump(str_chars);
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        if (!has_error && !nul_seen)
            decode_byte(b);
        str_pos = bump(str_pos);
        if (last)
        begin
            if (!has_error && !nul_seen && cont_needed != 2'd0)
                mark_error(seq_lead_pos);
            v.ok = !has_error;
            v.chars = has_error ? '0 : str_chars;
            v.err_offset = has_error ? error_pos : '0;
            expected_verdicts.push_back(v);
            clear_string_state();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_result();
        verdict_t want;
        if (expected_verdicts.size() == 0)
            report_mismatch("result arrived with none expected");
        else
        begin
            want = expected_verdicts.pop_front();
            if (is_valid !== want.ok)
                report_mismatch($sformatf("is_valid got %0b want %0b", is_valid, want.ok));
            if (char_count !== want.chars)
                report_mismatch($sformatf("char_count got %0d want %0d",
                                          char_count, want.chars));
            if (error_offset !== want.err_offset)
                report_mismatch($sformatf("error_offset got %0d want %0d",
                                          error_offset, want.err_offset));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            data_valid <= 1'b0;
        else
        begin
            if (data_valid && !data_stall)
            begin
                predict_byte(data_byte, last_byte);
                bytes_unaccepted--;
            end
            if (!data_valid || !data_stall)
            begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = byte_queue.pop_front();
                    data_valid <= 1'b1;
                    data_byte <= next_item.value;
                    last_byte <= next_item.last;
                end
                else
                    data_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result();
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic flush_string();
        for (int i = 0; i < str_buf.size(); i++)
            byte_queue.push_back('{str_buf[i], i == str_buf.size() - 1});
        bytes_unaccepted += str_buf.size();
        bytes_queued += str_buf.size();
        str_buf.delete();
    endtask

    task automatic put_code(input logic [20:0] cp, input int n);
        case (n)
            1: str_buf.push_back({1'b0, cp[6:0]});
            2:
            begin
                str_buf.push_back({3'b110, cp[10:6]});
                str_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                str_buf.push_back({4'b1110, cp[15:12]});
                str_buf.push_back({2'b10, cp[11:6]});
                str_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                str_buf.push_back({5'b11110, cp[20:18]});
                str_buf.push_back({2'b10, cp[17:12]});
                str_buf.push_back({2'b10, cp[11:6]});
                str_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] pick_code(input int n);
        logic [20:0] cp;
        case (n)
            1: cp = ($urandom_range(0, 15) == 0) ? 21'h0 : 21'($urandom_range(1, 127));
            2: cp = 21'($urandom_range(32'h80, 32'h7FF));
            3:
            begin
                cp = 21'($urandom_range(32'h800, 32'hF7FF));
                if (cp >= 21'hD800)
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            case (n)
                1: cp = 21'h7F;
                2: cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
                3:
                    case ($urandom_range(0, 3))
                        0: cp = 21'h800;
                        1: cp = 21'hD7FF;
                        2: cp = 21'hE000;
                        default: cp = 21'hFFFF;
                    endcase
                default: cp = $urandom_range(0, 1) ? 21'h10000 : 21'h10FFFF;
            endcase
        end
        return cp;
    endfunction

    task automatic add_valid_char();
        int n;
        n = $urandom_range(1, 4);
        put_code(pick_code(n), n);
    endtask

    task automatic add_defect();
        int n;
        int keep;
        logic [20:0] cp;
        n = $urandom_range(2, 4);
        case ($urandom_range(0, 5))
            0: str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            1:
            begin
                str_buf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                repeat ($urandom_range(0, 3))
                    str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            2:
            begin
                put_code(pick_code(n), n);
                keep = $urandom_range(1, n - 1);
                repeat (n - keep)
                    void'(str_buf.pop_back());
            end
            3:
            begin
                if (n == 2)
                    cp = 21'($urandom_range(0, 32'h7F));
                else if (n == 3)
                    cp = 21'($urandom_range(0, 32'h7FF));
                else
                    cp = 21'($urandom_range(0, 32'hFFFF));
                put_code(cp, n);
            end
            4: put_code(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
            default: put_code(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
        endcase
    endtask

    task automatic add_random_string();
        int mode;
        int nchar;
        int bad_at;
        mode = $urandom_range(0, 9);
        nchar = $urandom_range(1, 10);
        if (mode < 6)
            repeat (nchar) add_valid_char();
        else if (mode < 9)
        begin
            bad_at = $urandom_range(0, nchar - 1);
            for (int i = 0; i < nchar; i++)
            begin
                if (i == bad_at)
                    add_defect();
                else
                    add_valid_char();
            end
        end
        else
            repeat ($urandom_range(1, 8))
                str_buf.push_back(8'($urandom));
        flush_string();
    endtask

    task automatic add_random_bytes(input int count);
        int target;
        target = bytes_queued + count;
        while (bytes_queued < target)
            add_random_string();
    endtask

    task automatic wait_drained();
        while (bytes_unaccepted != 0 || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_valid <= 1'b1;
        stop_at_nul <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        nul_mode = v;
    endtask

    initial
    begin
        send_idle_pct = 22;
        recv_stall_pct = 67;
        wait (rst_n === 1'b1);
        @(posedge clk);

        write_mode(1'b0);
        str_buf = '{8'h00, 8'h7F, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        flush_string();
        str_buf = '{8'h80};
        flush_string();
        str_buf = '{8'hC1, 8'hBF};
        flush_string();
        str_buf = '{8'hED, 8'hA0, 8'h80};
        flush_string();
        str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
        flush_string();
        str_buf = '{8'hFF, 8'h80, 8'h80, 8'h80};
        flush_string();
        str_buf = '{8'hE2, 8'h82};
        flush_string();
        wait_drained();

        write_mode(1'b1);
        str_buf = '{8'h41, 8'h00, 8'hFF};
        flush_string();
        str_buf = '{8'hC2, 8'h00};
        flush_string();

        add_random_bytes(180);
        wait_drained();
        add_random_bytes(180);
        wait_drained();

        send_idle_pct = 67;
        recv_stall_pct = 22;
        write_mode(1'b0);
        add_random_bytes(360);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_mode(1'b1);
        add_random_bytes(180);
        wait_drained();
        write_mode(1'b0);
        add_random_bytes(180);
        wait_drained();

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
